// File: rtl/core/bea_pkg.sv
// Shared constants and types for the button edge and auto-repeat core.
`timescale 1ns / 1ps
package bea_pkg;

    localparam int unsigned BUTTONS_W = 32;
    localparam int unsigned AXIS_W    = 8;
    localparam int unsigned DT_W      = 20;
    localparam int unsigned DZ_W      = 7;
    localparam int unsigned DELAY_W   = 24;
    localparam int unsigned TIMER_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE      = 3'd0,
        CFG_REPEAT_MASK   = 3'd1,
        CFG_FIRST_DELAY   = 3'd2,
        CFG_REPEAT_PERIOD = 3'd3
    } t_cfg_idx;

    localparam logic [DZ_W-1:0]      DEADZONE_RST      = 7'd20;
    localparam logic [BUTTONS_W-1:0] REPEAT_MASK_RST   = 32'd240;
    localparam logic [DELAY_W-1:0]   FIRST_DELAY_RST   = 24'd400000;
    localparam logic [DELAY_W-1:0]   REPEAT_PERIOD_RST = 24'd100000;

    localparam logic [AXIS_W-1:0] AXIS_CENTRE = 8'd128;

endpackage

// File: rtl/core/bea_sample_if.sv
// Input channel carrying one controller sample per item.
`timescale 1ns / 1ps
interface bea_sample_if;
    logic                             valid;
    logic                             ready;
    logic [bea_pkg::BUTTONS_W-1:0]    buttons_now;
    logic [bea_pkg::AXIS_W-1:0]       axis_x_raw;
    logic [bea_pkg::AXIS_W-1:0]       axis_y_raw;
    logic [bea_pkg::DT_W-1:0]         elapsed_us;

    modport source (output valid, buttons_now, axis_x_raw, axis_y_raw, elapsed_us,
                    input ready);
    modport sink   (input valid, buttons_now, axis_x_raw, axis_y_raw, elapsed_us,
                    output ready);
endinterface

// File: rtl/core/bea_result_if.sv
// Output channel carrying one conditioned result per item.
`timescale 1ns / 1ps
interface bea_result_if;
    logic                             valid;
    logic                             ready;
    logic [bea_pkg::BUTTONS_W-1:0]    held_buttons;
    logic [bea_pkg::BUTTONS_W-1:0]    pressed_buttons;
    logic [bea_pkg::BUTTONS_W-1:0]    released_buttons;
    logic [bea_pkg::BUTTONS_W-1:0]    repeat_buttons;
    logic signed [bea_pkg::AXIS_W-1:0] axis_x;
    logic signed [bea_pkg::AXIS_W-1:0] axis_y;

    modport source (output valid, held_buttons, pressed_buttons, released_buttons,
                    repeat_buttons, axis_x, axis_y, input ready);
    modport sink   (input valid, held_buttons, pressed_buttons, released_buttons,
                    repeat_buttons, axis_x, axis_y, output ready);
endinterface

// File: rtl/core/button_edge_autorepeat_core.sv
// Top level: button edges, axis deadzone and auto-repeat timer for controller samples.
// Each accepted sample's result is registered in the output register.
// Throughput: one sample per cycle while ready; the repeat timer updates on accept.
// Ready stays high while the output register is empty or being taken.
// Reset: synchronous, active low; clears button history, repeat timer and output valid,
// and loads the register defaults (deadzone 20, mask 240, delay 400000, period 100000).
`timescale 1ns / 1ps
module button_edge_autorepeat_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bea_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bea_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bea_sample_if.sink                         i_sample,
    bea_result_if.source                       o_result
);

    logic [bea_pkg::DZ_W-1:0]      r_deadzone;
    logic [bea_pkg::BUTTONS_W-1:0] r_repeat_mask;
    logic [bea_pkg::DELAY_W-1:0]   r_first_delay;
    logic [bea_pkg::DELAY_W-1:0]   r_repeat_period;

    logic [bea_pkg::BUTTONS_W-1:0] r_prev_buttons;
    logic [bea_pkg::BUTTONS_W-1:0] r_tracked_set;
    logic [bea_pkg::TIMER_W-1:0]   r_timer;
    logic                          r_started;

    logic [bea_pkg::BUTTONS_W-1:0] n_tracked_set;
    logic [bea_pkg::TIMER_W-1:0]   n_timer;
    logic                          n_started;

    logic                          r_valid;
    logic [bea_pkg::BUTTONS_W-1:0] r_held;
    logic [bea_pkg::BUTTONS_W-1:0] r_pressed;
    logic [bea_pkg::BUTTONS_W-1:0] r_released;
    logic [bea_pkg::BUTTONS_W-1:0] r_repeat;
    logic signed [bea_pkg::AXIS_W-1:0] r_axis_x;
    logic signed [bea_pkg::AXIS_W-1:0] r_axis_y;

    logic                          accept;
    logic [bea_pkg::BUTTONS_W-1:0] pressed;
    logic [bea_pkg::BUTTONS_W-1:0] released;
    logic [bea_pkg::BUTTONS_W-1:0] rep_set;
    logic [bea_pkg::BUTTONS_W-1:0] n_repeat;
    logic [bea_pkg::TIMER_W:0]     sum_wide;
    logic [bea_pkg::TIMER_W-1:0]   sum_sat;
    logic [bea_pkg::TIMER_W-1:0]   threshold;
    logic signed [bea_pkg::AXIS_W-1:0] axis_x;
    logic signed [bea_pkg::AXIS_W-1:0] axis_y;

    assign i_sample.ready = !r_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;

    assign pressed  = i_sample.buttons_now & ~r_prev_buttons;
    assign released = ~i_sample.buttons_now & r_prev_buttons;
    assign rep_set  = i_sample.buttons_now & r_repeat_mask;

    assign sum_wide  = {1'b0, r_timer} + {{(bea_pkg::TIMER_W + 1 - bea_pkg::DT_W){1'b0}},
                                          i_sample.elapsed_us};
    assign sum_sat   = sum_wide[bea_pkg::TIMER_W] ? '1 : sum_wide[bea_pkg::TIMER_W-1:0];
    assign threshold = {{(bea_pkg::TIMER_W - bea_pkg::DELAY_W){1'b0}},
                        (r_started ? r_repeat_period : r_first_delay)};

    always_comb begin
        n_tracked_set = r_tracked_set;
        n_timer       = r_timer;
        n_started     = r_started;
        n_repeat      = pressed;
        if (rep_set != r_tracked_set) begin
            n_tracked_set = rep_set;
            n_timer       = '0;
            n_started     = 1'b0;
        end else if (rep_set != '0) begin
            n_timer = sum_sat;
            if (sum_sat >= threshold) begin
                n_timer   = sum_sat - threshold;
                n_started = 1'b1;
                n_repeat  = pressed | rep_set;
            end
        end
    end

    bea_axis u_axis_x (
        .i_raw      (i_sample.axis_x_raw),
        .i_deadzone (r_deadzone),
        .o_axis     (axis_x)
    );

    bea_axis u_axis_y (
        .i_raw      (i_sample.axis_y_raw),
        .i_deadzone (r_deadzone),
        .o_axis     (axis_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone      <= bea_pkg::DEADZONE_RST;
            r_repeat_mask   <= bea_pkg::REPEAT_MASK_RST;
            r_first_delay   <= bea_pkg::FIRST_DELAY_RST;
            r_repeat_period <= bea_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bea_pkg::CFG_DEADZONE:      r_deadzone      <= i_cfg_data[bea_pkg::DZ_W-1:0];
                bea_pkg::CFG_REPEAT_MASK:   r_repeat_mask   <= i_cfg_data;
                bea_pkg::CFG_FIRST_DELAY:   r_first_delay   <= i_cfg_data[bea_pkg::DELAY_W-1:0];
                bea_pkg::CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data[bea_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_tracked_set  <= '0;
            r_timer        <= '0;
            r_started      <= 1'b0;
            r_valid        <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_buttons <= i_sample.buttons_now;
                r_tracked_set  <= n_tracked_set;
                r_timer        <= n_timer;
                r_started      <= n_started;
                r_valid        <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held     <= i_sample.buttons_now;
            r_pressed  <= pressed;
            r_released <= released;
            r_repeat   <= n_repeat;
            r_axis_x   <= axis_x;
            r_axis_y   <= axis_y;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.held_buttons     = r_held;
    assign o_result.pressed_buttons  = r_pressed;
    assign o_result.released_buttons = r_released;
    assign o_result.repeat_buttons   = r_repeat;
    assign o_result.axis_x           = r_axis_x;
    assign o_result.axis_y           = r_axis_y;

endmodule

// File: rtl/core/bea_axis.sv
// Axis re-centering and deadzone for one analog stick axis.
`timescale 1ns / 1ps
module bea_axis (
    input  logic [bea_pkg::AXIS_W-1:0]        i_raw,
    input  logic [bea_pkg::DZ_W-1:0]          i_deadzone,
    output logic signed [bea_pkg::AXIS_W-1:0] o_axis
);

    logic signed [bea_pkg::AXIS_W-1:0] centred;
    logic signed [bea_pkg::AXIS_W:0]   wide;
    logic signed [bea_pkg::AXIS_W:0]   dz_pos;
    logic signed [bea_pkg::AXIS_W:0]   dz_neg;
    logic                              outside;

    assign centred = signed'(i_raw ^ bea_pkg::AXIS_CENTRE);
    assign wide    = {centred[bea_pkg::AXIS_W-1], centred};
    assign dz_pos  = signed'({2'b00, i_deadzone});
    assign dz_neg  = -dz_pos;
    assign outside = (wide > dz_pos) || (wide < dz_neg);
    assign o_axis  = outside ? centred : '0;

endmodule
